[sv/b92sd_pkg.sv]
// Shared types, alphabet constants and symbol lookup for the base92 stream decoder.
package b92sd_pkg;

    // Input word: one text character plus the end-of-message flag.
    typedef struct packed {
        logic [7:0] in_char;
        logic       is_final;
    } t_in;

    // Output word: one decoded byte plus framing flags.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       message_end;
    } t_out;

    // Symbol lookup result.
    typedef struct packed {
        logic       ok;
        logic [6:0] value;
    } t_sym;

    localparam logic [7:0]  CH_FIRST  = 8'd33;
    localparam logic [7:0]  CH_LAST   = 8'd126;
    localparam logic [7:0]  CH_QUOTE  = 8'd34;
    localparam logic [7:0]  CH_BSLASH = 8'd92;
    localparam logic [13:0] RADIX     = 14'd92;
    localparam int          PAIR_BITS = 13;
    localparam int          TAIL_BITS = 7;

    // Map a character to its position in the 92-symbol alphabet.
    function automatic t_sym sym_decode(input logic [7:0] c);
        t_sym       r;
        logic [7:0] v;
        v = c - CH_FIRST;
        if (c > CH_QUOTE) begin
            v = v - 8'd1;
        end
        if (c > CH_BSLASH) begin
            v = v - 8'd1;
        end
        r.ok    = !((c < CH_FIRST) || (c > CH_LAST) || (c == CH_QUOTE) || (c == CH_BSLASH));
        r.value = v[6:0];
        return r;
    endfunction

endpackage

[sv/base92_stream_decoder.sv]
// Base92 stream decoder: character words in, decoded byte words out.
// A result word is registered and appears on the output in the cycle after its character is accepted.
// Throughput: one character per cycle while the consumer does not stall; a character that
//   completes two bytes holds the input while its second word waits, since the output port moves one word per cycle.
// Reset (i_rst_n low, synchronous): drops any held symbol, leftover bits and queued words.
module base92_stream_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  b92sd_pkg::t_in    i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output b92sd_pkg::t_out   o_data
);

    // Decoder state: an unpaired symbol and up to seven undelivered bits.
    logic [6:0] r_held_sym;
    logic       r_sym_held;
    logic [6:0] r_left_bits;
    logic [2:0] r_left_cnt;

    // Result buffer: up to two words from one character, slot 0 shown on the port.
    b92sd_pkg::t_out r_buf0;
    b92sd_pkg::t_out r_buf1;
    logic [1:0]      r_buf_cnt;

    logic            in_take;
    logic            out_take;
    b92sd_pkg::t_sym sym;

    logic [13:0] pair_val;
    logic [19:0] pair_acc;
    logic [4:0]  pair_tot;
    logic [4:0]  pair_rem;
    logic [19:0] pair_mask;
    logic        pair_two;
    logic [7:0]  pair_b0;
    logic [7:0]  pair_b1;
    logic [6:0]  pair_left;

    logic [6:0]  tail_sym;
    logic [13:0] tail_acc;
    logic [7:0]  tail_b;

    logic do_pair;
    logic do_tail;

    b92sd_pkg::t_out n_res0;
    b92sd_pkg::t_out n_res1;
    logic [1:0]      n_num;

    // Output side: a word waits in slot 0 while the consumer stalls.
    assign o_valid  = (r_buf_cnt != 2'd0);
    assign o_data   = r_buf0;
    assign out_take = o_valid && !i_stall;

    // Take a new character once the buffer drains this cycle, so a single-word
    // result does not block the next character unless the consumer stalls.
    assign o_stall  = !((r_buf_cnt == 2'd0) || ((r_buf_cnt == 2'd1) && !i_stall));
    assign in_take  = i_valid && !o_stall;

    assign sym = b92sd_pkg::sym_decode(i_data.in_char);

    // Pair a held symbol with the new one; the shift and the OR let the top bit
    // of a large pair value fall onto the lowest leftover bit.
    always_comb begin
        pair_val  = {7'd0, r_held_sym} + ({7'd0, sym.value} * b92sd_pkg::RADIX);
        pair_acc  = {r_left_bits, 13'd0} | {6'd0, pair_val};
        pair_tot  = {2'd0, r_left_cnt} + 5'(b92sd_pkg::PAIR_BITS);
        pair_two  = (pair_tot >= 5'd16);
        pair_b0   = 8'(pair_acc >> (pair_tot - 5'd8));
        pair_b1   = 8'(pair_acc >> (pair_tot - 5'd16));
        pair_rem  = pair_two ? (pair_tot - 5'd16) : (pair_tot - 5'd8);
        pair_mask = (20'd1 << pair_rem) - 20'd1;
        pair_left = 7'(pair_acc & pair_mask);
    end

    // Flush of a lone symbol at message end: it adds seven bits, and a byte comes
    // out whenever any leftover bit was waiting.
    always_comb begin
        tail_sym = sym.ok ? sym.value : r_held_sym;
        tail_acc = {r_left_bits, 7'd0} | {7'd0, tail_sym};
        tail_b   = 8'(tail_acc >> (r_left_cnt - 3'd1));
    end

    assign do_pair = sym.ok && r_sym_held;
    assign do_tail = i_data.is_final && (sym.ok ^ r_sym_held);

    // Assemble the words this character causes, then flag the last one.
    always_comb begin
        n_res0 = '0;
        n_res1 = '0;
        n_num  = 2'd0;
        if (do_pair) begin
            n_res0.out_byte   = pair_b0;
            n_res0.byte_valid = 1'b1;
            n_num             = 2'd1;
            if (pair_two) begin
                n_res1.out_byte   = pair_b1;
                n_res1.byte_valid = 1'b1;
                n_num             = 2'd2;
            end
        end else if (do_tail && (r_left_cnt != 3'd0)) begin
            n_res0.out_byte   = tail_b;
            n_res0.byte_valid = 1'b1;
            n_num             = 2'd1;
        end
        // A final character always answers, with a bare end marker if need be.
        if (i_data.is_final && (n_num == 2'd0)) begin
            n_num = 2'd1;
        end
        if (n_num == 2'd2) begin
            n_res1.run_last    = 1'b1;
            n_res1.message_end = i_data.is_final;
        end else begin
            n_res0.run_last    = (n_num == 2'd1);
            n_res0.message_end = i_data.is_final && (n_num == 2'd1);
        end
    end

    // Decoder state: advance on each accepted character that holds a valid symbol, clear at message end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_sym  <= '0;
            r_sym_held  <= 1'b0;
            r_left_bits <= '0;
            r_left_cnt  <= '0;
        end else if (in_take) begin
            if (i_data.is_final) begin
                r_held_sym  <= '0;
                r_sym_held  <= 1'b0;
                r_left_bits <= '0;
                r_left_cnt  <= '0;
            end else if (do_pair) begin
                r_held_sym  <= '0;
                r_sym_held  <= 1'b0;
                r_left_bits <= pair_left;
                r_left_cnt  <= pair_rem[2:0];
            end else if (sym.ok) begin
                r_held_sym <= sym.value;
                r_sym_held <= 1'b1;
            end
        end
    end

    // Result buffer: load on accept, otherwise shift slot 1 forward as words leave.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_cnt <= 2'd0;
        end else if (in_take) begin
            r_buf_cnt <= n_num;
        end else if (out_take) begin
            r_buf_cnt <= r_buf_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_buf0 <= n_res0;
            r_buf1 <= n_res1;
        end else if (out_take) begin
            r_buf0 <= r_buf1;
        end
    end

endmodule
